// ----- hdl/trce_pkg.sv -----
// shared types and constants of the tcp rtt / rto / congestion window engine
// no dependencies; imported by every other file of the block

package trce_pkg;

  localparam int TIME_WIDTH = 20;
  localparam int WIN_WIDTH  = 21;
  localparam int CFG_WIDTH  = 20;
  localparam int IDX_WIDTH  = 1;

  localparam logic [WIN_WIDTH-1:0]  CWND_MAX        = WIN_WIDTH'(1048576);
  localparam logic [WIN_WIDTH-1:0]  CWND_INIT       = WIN_WIDTH'(10);
  localparam logic [WIN_WIDTH-1:0]  CWND_LOSS       = WIN_WIDTH'(1);
  localparam logic [WIN_WIDTH-1:0]  SSTHRESH_MIN    = WIN_WIDTH'(2);
  localparam logic [TIME_WIDTH-1:0] RTO_INIT        = TIME_WIDTH'(3000);
  localparam logic [TIME_WIDTH-1:0] RTO_FLOOR_RESET = TIME_WIDTH'(200);
  localparam logic [TIME_WIDTH-1:0] RTO_CEIL_RESET  = TIME_WIDTH'(120000);

  typedef enum logic {
    OP_ACK     = 1'b0,
    OP_TIMEOUT = 1'b1
  } op_t;

  typedef enum logic [IDX_WIDTH-1:0] {
    REG_RTO_FLOOR   = 1'b0,
    REG_RTO_CEILING = 1'b1
  } reg_idx_t;

  typedef struct packed {
    op_t                   op;
    logic                  rtt_valid;
    logic [TIME_WIDTH-1:0] rtt_sample;
  } evt_t;

  typedef struct packed {
    logic [TIME_WIDTH-1:0] srtt;
    logic [TIME_WIDTH-1:0] rttvar;
    logic [TIME_WIDTH-1:0] rto;
  } time_state_t;

  typedef struct packed {
    logic [WIN_WIDTH-1:0] cwnd;
    logic [WIN_WIDTH-1:0] ssthresh;
  } win_state_t;

  typedef struct packed {
    logic [TIME_WIDTH-1:0] floor_ms;
    logic [TIME_WIDTH-1:0] ceil_ms;
  } rto_limits_t;

endpackage

// ----- hdl/trce_evt_if.sv -----
// event channel: valid/ready handshake carrying one connection event
// depends on trce_pkg

interface trce_evt_if import trce_pkg::*; ();
  logic                  valid;
  logic                  ready;
  op_t                   op;
  logic                  rtt_valid;
  logic [TIME_WIDTH-1:0] rtt_sample;

  modport source (output valid, op, rtt_valid, rtt_sample, input ready);
  modport sink   (input valid, op, rtt_valid, rtt_sample, output ready);
endinterface

// ----- hdl/trce_rsp_if.sv -----
// result channel: valid/ready handshake carrying the connection state after an event
// depends on trce_pkg

interface trce_rsp_if import trce_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [WIN_WIDTH-1:0]  cong_window;
  logic [WIN_WIDTH-1:0]  slow_start_limit;
  logic [TIME_WIDTH-1:0] timeout_ms;
  logic [TIME_WIDTH-1:0] smoothed_rtt;
  logic [TIME_WIDTH-1:0] rtt_variation;

  modport source (output valid, cong_window, slow_start_limit, timeout_ms,
                  smoothed_rtt, rtt_variation, input ready);
  modport sink   (input valid, cong_window, slow_start_limit, timeout_ms,
                  smoothed_rtt, rtt_variation, output ready);
endinterface

// ----- hdl/trce_rtt.sv -----
// next srtt, rttvar and rto for one event (smoothing, clamp, timeout backoff)
// depends on trce_pkg

module trce_rtt import trce_pkg::*; (
  input  evt_t        evt,
  input  time_state_t cur,
  input  rto_limits_t limits,
  output time_state_t nxt
);

  logic [TIME_WIDTH-1:0] diff;
  logic [TIME_WIDTH+1:0] var_sum;
  logic [TIME_WIDTH+2:0] srtt_sum;
  logic [TIME_WIDTH-1:0] srtt_upd;
  logic [TIME_WIDTH-1:0] rttvar_upd;
  logic [TIME_WIDTH+2:0] rto_raw;
  logic [TIME_WIDTH+2:0] rto_floored;
  logic [TIME_WIDTH-1:0] rto_upd;
  logic [TIME_WIDTH:0]   rto_dbl;

  always_comb begin
    diff = (cur.srtt >= evt.rtt_sample) ? cur.srtt - evt.rtt_sample
                                        : evt.rtt_sample - cur.srtt;
    // 3*rttvar + |err|, then / 4
    var_sum  = {2'b00, cur.rttvar} + {1'b0, cur.rttvar, 1'b0} + {2'b00, diff};
    // 7*srtt + sample, then / 8
    srtt_sum = {cur.srtt, 3'b000} - {3'b000, cur.srtt} + {3'b000, evt.rtt_sample};

    // zero srtt is taken as no sample seen yet
    if (cur.srtt == '0) begin
      srtt_upd   = evt.rtt_sample;
      rttvar_upd = evt.rtt_sample >> 1;
    end else begin
      srtt_upd   = srtt_sum[TIME_WIDTH+2:3];
      rttvar_upd = var_sum[TIME_WIDTH+1:2];
    end

    // floor first, ceiling second so the ceiling wins
    rto_raw     = {3'b000, srtt_upd} + {1'b0, rttvar_upd, 2'b00};
    rto_floored = (rto_raw < {3'b000, limits.floor_ms}) ? {3'b000, limits.floor_ms} : rto_raw;
    rto_upd     = (rto_floored > {3'b000, limits.ceil_ms}) ? limits.ceil_ms
                                                           : rto_floored[TIME_WIDTH-1:0];

    rto_dbl = {cur.rto, 1'b0};

    nxt = cur;
    if (evt.op == OP_TIMEOUT) begin
      nxt.rto = (rto_dbl > {1'b0, limits.ceil_ms}) ? limits.ceil_ms
                                                   : rto_dbl[TIME_WIDTH-1:0];
    end else if (evt.rtt_valid) begin
      nxt.srtt   = srtt_upd;
      nxt.rttvar = rttvar_upd;
      nxt.rto    = rto_upd;
    end
  end

endmodule

// ----- hdl/trce_win.sv -----
// next congestion window and slow start threshold for one event
// depends on trce_pkg

module trce_win import trce_pkg::*; (
  input  op_t        op,
  input  win_state_t cur,
  output win_state_t nxt
);

  logic [WIN_WIDTH-1:0] inc;
  logic [WIN_WIDTH-1:0] half;

  always_comb begin
    inc  = cur.cwnd + WIN_WIDTH'(1);
    half = cur.cwnd >> 1;
    nxt  = cur;
    if (op == OP_TIMEOUT) begin
      nxt.ssthresh = (half > SSTHRESH_MIN) ? half : SSTHRESH_MIN;
      nxt.cwnd     = CWND_LOSS;
    end else begin
      priority if (cur.cwnd < cur.ssthresh) begin
        // slow start, never past ssthresh
        nxt.cwnd = (inc >= cur.ssthresh) ? cur.ssthresh : inc;
      end else if (cur.cwnd < CWND_MAX) begin
        nxt.cwnd = inc;
      end else begin
        nxt.cwnd = cur.cwnd;
      end
      if (nxt.cwnd > CWND_MAX) begin
        nxt.cwnd = CWND_MAX;
      end
    end
  end

endmodule

// ----- hdl/tcp_rtt_rto_cwnd_engine_core.sv -----
// an event passes the input register, then the state register that also serves as the
//   result register
// throughput: one event per cycle back to back unless a result stalls; the state update is
//   one pass through the rtt/rto and window logic between the input and state registers
// the state registers are the result register; a stalled result holds both the state
//   and the input register, and the input register still takes one event while a result waits
// reset (rst, synchronous, active high): cwnd 10, ssthresh 1048576, srtt 0, rttvar 0,
//   rto 3000 ms, rto floor 200 ms, rto ceiling 120000 ms; both channels empty

module tcp_rtt_rto_cwnd_engine_core import trce_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [IDX_WIDTH-1:0] cfg_index,
  input  logic [CFG_WIDTH-1:0] cfg_data,
  trce_evt_if.sink             evt,
  trce_rsp_if.source           rsp
);

  // configuration registers
  rto_limits_t limits;

  // input register stage
  logic        s1_valid;
  evt_t        s1_evt;

  // connection state, also the result register
  time_state_t tstate;
  win_state_t  wstate;
  logic        rsp_valid;

  time_state_t tstate_next;
  win_state_t  wstate_next;

  logic        advance;   // input register moves into the state
  logic        evt_xfer;

  // the state can take the buffered event whenever no result is waiting or the waiting result transfers
  assign advance  = s1_valid && (!rsp_valid || rsp.ready);
  assign evt.ready = !s1_valid || advance;
  assign evt_xfer = evt.valid && evt.ready;

  // config writes; the user must issue them only while idle, the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      limits.floor_ms <= RTO_FLOOR_RESET;
      limits.ceil_ms  <= RTO_CEIL_RESET;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_RTO_FLOOR:   limits.floor_ms <= cfg_data[TIME_WIDTH-1:0];
        REG_RTO_CEILING: limits.ceil_ms  <= cfg_data[TIME_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (evt.ready) begin
      s1_valid <= evt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (evt_xfer) begin
      s1_evt.op         <= evt.op;
      s1_evt.rtt_valid  <= evt.rtt_valid;
      s1_evt.rtt_sample <= evt.rtt_sample;
    end
  end

  // rtt estimator and rto clamp / backoff
  trce_rtt u_rtt (
    .evt    (s1_evt),
    .cur    (tstate),
    .limits (limits),
    .nxt    (tstate_next)
  );

  // reno window
  trce_win u_win (
    .op  (s1_evt.op),
    .cur (wstate),
    .nxt (wstate_next)
  );

  // state / result register
  always_ff @(posedge clk) begin
    if (rst) begin
      tstate.srtt     <= '0;
      tstate.rttvar   <= '0;
      tstate.rto      <= RTO_INIT;
      wstate.cwnd     <= CWND_INIT;
      wstate.ssthresh <= CWND_MAX;
      rsp_valid       <= 1'b0;
    end else begin
      if (advance) begin
        tstate <= tstate_next;
        wstate <= wstate_next;
      end
      // valid follows the last update; cleared once the result transfers
      if (advance) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  assign rsp.valid            = rsp_valid;
  assign rsp.cong_window      = wstate.cwnd;
  assign rsp.slow_start_limit = wstate.ssthresh;
  assign rsp.timeout_ms       = tstate.rto;
  assign rsp.smoothed_rtt     = tstate.srtt;
  assign rsp.rtt_variation    = tstate.rttvar;

  // a timeout always collapses the window to one segment
  a_timeout_collapse: assert property (@(posedge clk) disable iff (rst)
    advance && s1_evt.op == OP_TIMEOUT |=> wstate.cwnd == CWND_LOSS)
    else $error("cwnd not one after timeout");

  // window and threshold stay in range
  a_win_range: assert property (@(posedge clk) disable iff (rst)
    wstate.cwnd <= CWND_MAX && wstate.cwnd != '0 &&
    wstate.ssthresh <= CWND_MAX && wstate.ssthresh >= SSTHRESH_MIN)
    else $error("window state out of range");

  // without an advance the connection state does not move
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(tstate) && $stable(wstate))
    else $error("state changed without an event");

  // an event taken while the input register is full must be a pass-through
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    evt_xfer && s1_valid |-> advance)
    else $error("input register overwritten");

  // each advance produces a visible result the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    advance |=> rsp_valid)
    else $error("result missing after update");

endmodule

// ----- test/tb_top.sv -----
// self-checking bench for the tcp rtt / rto / congestion window engine
// drives events and config writes, predicts every result transfer and checks it
// depends on trce_pkg, trce_evt_if, trce_rsp_if and tcp_rtt_rto_cwnd_engine_core

module tb_top import trce_pkg::*; ();

  // cycles without any transfer before the run is declared hung
  localparam int HANG_LIMIT = 4000;
  localparam logic [63:0] MS_MAX = (64'd1 << TIME_WIDTH) - 64'd1;

  typedef struct {
    logic [WIN_WIDTH-1:0]  cwnd;
    logic [WIN_WIDTH-1:0]  ssthresh;
    logic [TIME_WIDTH-1:0] rto;
    logic [TIME_WIDTH-1:0] srtt;
    logic [TIME_WIDTH-1:0] rttvar;
  } conn_result_t;

  // keeps its own copy of the connection state and the rto limits
  class conn_state_scoreboard;
    logic [63:0]  cwnd, ssthresh, srtt, rttvar, rto;
    logic [63:0]  rto_floor, rto_ceiling;
    conn_result_t expected_states[$];
    int           errors;

    function new();
      cwnd        = 64'(CWND_INIT);
      ssthresh    = 64'(CWND_MAX);
      srtt        = '0;
      rttvar      = '0;
      rto         = 64'(RTO_INIT);
      rto_floor   = 64'(RTO_FLOOR_RESET);
      rto_ceiling = 64'(RTO_CEIL_RESET);
      errors      = 0;
    endfunction

    function logic [63:0] clip_ms(logic [63:0] v);
      return (v > MS_MAX) ? MS_MAX : v;
    endfunction

    function void set_limit(reg_idx_t idx, logic [CFG_WIDTH-1:0] value);
      if (idx == REG_RTO_FLOOR) rto_floor = 64'(value);
      else rto_ceiling = 64'(value);
    endfunction

    function int pending();
      return expected_states.size();
    endfunction

    // one event in, connection state after it out
    function void advance_connection(op_t op, logic rtt_valid, logic [TIME_WIDTH-1:0] sample);
      logic [63:0] smp, diff, r, half;
      conn_result_t res;
      smp = 64'(sample);
      if (op == OP_ACK) begin
        if (rtt_valid) begin
          if (srtt == 0) begin
            // first sample, every sample so far was zero, or srtt has decayed to zero
            srtt   = smp;
            rttvar = smp >> 1;
          end else begin
            diff   = (srtt >= smp) ? srtt - smp : smp - srtt;
            rttvar = clip_ms((64'd3 * rttvar + diff) >> 2);
            srtt   = clip_ms((64'd7 * srtt + smp) >> 3);
          end
          // floor first, ceiling second: the ceiling wins when they cross
          r = srtt + (rttvar << 2);
          if (r < rto_floor) r = rto_floor;
          if (r > rto_ceiling) r = rto_ceiling;
          rto = clip_ms(r);
        end
        if (cwnd < ssthresh) begin
          cwnd = cwnd + 1;
          if (cwnd >= ssthresh) cwnd = ssthresh;
        end else if (cwnd < 64'(CWND_MAX)) begin
          cwnd = cwnd + 1;
        end
        if (cwnd > 64'(CWND_MAX)) cwnd = 64'(CWND_MAX);
      end else begin
        // backoff: no floor, saturate at the ceiling
        half     = cwnd >> 1;
        r        = rto << 1;
        ssthresh = (half > 64'(SSTHRESH_MIN)) ? half : 64'(SSTHRESH_MIN);
        cwnd     = 64'(CWND_LOSS);
        if (r > rto_ceiling) r = rto_ceiling;
        rto = clip_ms(r);
      end
      res.cwnd     = WIN_WIDTH'(cwnd);
      res.ssthresh = WIN_WIDTH'(ssthresh);
      res.rto      = TIME_WIDTH'(rto);
      res.srtt     = TIME_WIDTH'(srtt);
      res.rttvar   = TIME_WIDTH'(rttvar);
      expected_states.push_back(res);
    endfunction

    function void note_event(op_t op, logic rtt_valid, logic [TIME_WIDTH-1:0] sample);
      advance_connection(op, rtt_valid, sample);
    endfunction

    function void check_state(conn_result_t got);
      conn_result_t exp;
      if (expected_states.size() == 0) begin
        $error("result transfer with no event pending");
        errors++;
        return;
      end
      exp = expected_states.pop_front();
      if (got.cwnd !== exp.cwnd) begin
        $error("cong_window: expected %0d, actual %0d", exp.cwnd, got.cwnd);
        errors++;
      end
      if (got.ssthresh !== exp.ssthresh) begin
        $error("slow_start_limit: expected %0d, actual %0d", exp.ssthresh, got.ssthresh);
        errors++;
      end
      if (got.rto !== exp.rto) begin
        $error("timeout_ms: expected %0d, actual %0d", exp.rto, got.rto);
        errors++;
      end
      if (got.srtt !== exp.srtt) begin
        $error("smoothed_rtt: expected %0d, actual %0d", exp.srtt, got.srtt);
        errors++;
      end
      if (got.rttvar !== exp.rttvar) begin
        $error("rtt_variation: expected %0d, actual %0d", exp.rttvar, got.rttvar);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic                 cfg_we;
  logic [IDX_WIDTH-1:0] cfg_index;
  logic [CFG_WIDTH-1:0] cfg_data;

  trce_evt_if evt_ch ();
  trce_rsp_if rsp_ch ();

  tcp_rtt_rto_cwnd_engine_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .evt       (evt_ch),
    .rsp       (rsp_ch)
  );

  conn_state_scoreboard sb;

  // idle chances in percent, changed per phase
  int sender_idle_pct;
  int receiver_idle_pct;
  int quiet_cycles;

  always #5 clk = ~clk;

  // hang detector: any transfer on either channel restarts the count
  always @(posedge clk) begin
    if ((evt_ch.valid && evt_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HANG_LIMIT) begin
      $display("** tcp_rtt_rto_cwnd_engine_core: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one event transfer, with random idle cycles ahead of it
  task automatic send_event(input op_t op, input logic rtt_valid,
                            input logic [TIME_WIDTH-1:0] sample);
    while ($urandom_range(99) < sender_idle_pct) begin
      evt_ch.valid <= 1'b0;
      @(posedge clk);
    end
    evt_ch.valid      <= 1'b1;
    evt_ch.op         <= op;
    evt_ch.rtt_valid  <= rtt_valid;
    evt_ch.rtt_sample <= sample;
    @(posedge clk);
    while (!evt_ch.ready) @(posedge clk);
    sb.note_event(op, rtt_valid, sample);
  endtask

  // result side: random back-pressure, every transfer goes to the scoreboard
  task automatic take_results();
    conn_result_t got;
    forever begin
      rsp_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
      @(posedge clk);
      if (rsp_ch.valid && rsp_ch.ready) begin
        got.cwnd     = rsp_ch.cong_window;
        got.ssthresh = rsp_ch.slow_start_limit;
        got.rto      = rsp_ch.timeout_ms;
        got.srtt     = rsp_ch.smoothed_rtt;
        got.rttvar   = rsp_ch.rtt_variation;
        sb.check_state(got);
      end
    end
  endtask

  // stop sending and wait until every result has come back
  task automatic drain();
    evt_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_limits(input logic [CFG_WIDTH-1:0] floor_ms,
                              input logic [CFG_WIDTH-1:0] ceil_ms);
    cfg_we    <= 1'b1;
    cfg_index <= REG_RTO_FLOOR;
    cfg_data  <= floor_ms;
    @(posedge clk);
    sb.set_limit(REG_RTO_FLOOR, floor_ms);
    cfg_index <= REG_RTO_CEILING;
    cfg_data  <= ceil_ms;
    @(posedge clk);
    sb.set_limit(REG_RTO_CEILING, ceil_ms);
    cfg_we <= 1'b0;
  endtask

  // mostly samples jittering around a base rtt, with zeros, maxima and wild values
  function automatic logic [TIME_WIDTH-1:0] pick_sample(input int base);
    int pick;
    int lo;
    pick = $urandom_range(99);
    if (pick < 5) return '0;
    if (pick < 10) return '1;
    if (pick < 25) return TIME_WIDTH'($urandom);
    lo = (base > 500) ? base - 500 : 0;
    return TIME_WIDTH'($urandom_range(base + 500, lo));
  endfunction

  task automatic random_events(input int count);
    int base;
    int kind;
    int run_len;
    base = $urandom_range(4000, 1);
    for (int k = 0; k < count; k++) begin
      kind = $urandom_range(99);
      if (kind < 3) begin
        // timeout run, drives the backoff toward the ceiling
        run_len = $urandom_range(6, 3);
        repeat (run_len) send_event(OP_TIMEOUT, 1'($urandom), TIME_WIDTH'($urandom));
      end else if (kind < 12) begin
        send_event(OP_TIMEOUT, 1'($urandom), TIME_WIDTH'($urandom));
      end else if (kind < 22) begin
        // ack without a sample, sample bits are noise
        send_event(OP_ACK, 1'b0, TIME_WIDTH'($urandom));
      end else begin
        send_event(OP_ACK, 1'b1, pick_sample(base));
      end
      // path change now and then
      if (kind == 99) base = $urandom_range(4000, 1);
    end
  endtask

  initial begin
    logic [CFG_WIDTH-1:0] floors [6];
    logic [CFG_WIDTH-1:0] ceils [6];

    sb = new();
    rst               <= 1'b1;
    cfg_we            <= 1'b0;
    cfg_index         <= REG_RTO_FLOOR;
    cfg_data          <= '0;
    evt_ch.valid      <= 1'b0;
    evt_ch.op         <= OP_ACK;
    evt_ch.rtt_valid  <= 1'b0;
    evt_ch.rtt_sample <= '0;
    rsp_ch.ready      <= 1'b0;
    sender_idle_pct   = 22;
    receiver_idle_pct = 74;

    // extremes, crossed limits, random, the reset values, random and a fixed pair
    floors[0] = 20'd1;       ceils[0] = '1;
    floors[1] = '1;          ceils[1] = 20'd1;
    floors[2] = CFG_WIDTH'($urandom_range(3000, 1));
    ceils[2]  = CFG_WIDTH'($urandom_range(200000, 1000));
    floors[3] = RTO_FLOOR_RESET; ceils[3] = RTO_CEIL_RESET;
    floors[4] = CFG_WIDTH'($urandom_range(1048575, 1));
    ceils[4]  = CFG_WIDTH'($urandom_range(1048575, 1));
    floors[5] = 20'd500;     ceils[5] = 20'd60000;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    fork
      take_results();
    join_none

    // directed part under the reset limits
    send_event(OP_ACK, 1'b0, '1);              // sample ignored without rtt_valid
    send_event(OP_ACK, 1'b1, '0);              // zero first sample keeps srtt at zero
    send_event(OP_ACK, 1'b1, '0);
    send_event(OP_ACK, 1'b1, 20'd100);         // real first sample
    send_event(OP_ACK, 1'b1, '1);              // largest sample, rto at the ceiling
    send_event(OP_ACK, 1'b1, '0);
    send_event(OP_TIMEOUT, 1'b1, 20'd5);       // sample ignored on a timeout
    repeat (3) send_event(OP_TIMEOUT, 1'b0, '0); // backoff saturates, ssthresh to its minimum
    repeat (6) send_event(OP_ACK, 1'b0, '0);   // slow start capped at ssthresh, then avoidance
    repeat (4) send_event(OP_ACK, 1'b1, '1);   // srtt climbs toward the top of the range
    send_event(OP_ACK, 1'b1, 20'd1);
    send_event(OP_TIMEOUT, 1'b0, '1);

    // random part: two limit settings per idling mode
    for (int seg = 0; seg < 6; seg++) begin
      drain();
      unique case (seg / 2)
        0: begin
          sender_idle_pct   = 22;
          receiver_idle_pct = 74;
        end
        1: begin
          sender_idle_pct   = 74;
          receiver_idle_pct = 22;
        end
        default: begin
          sender_idle_pct   = 0;
          receiver_idle_pct = 0;
        end
      endcase
      write_limits(floors[seg], ceils[seg]);
      random_events(130);
    end

    drain();
    // a stray result would still show up here
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("** tcp_rtt_rto_cwnd_engine_core: PASSED **");
    end else begin
      $display("** tcp_rtt_rto_cwnd_engine_core: FAILED **");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/trce_pkg.sv
hdl/trce_evt_if.sv
hdl/trce_rsp_if.sv
hdl/trce_rtt.sv
hdl/trce_win.sv
hdl/tcp_rtt_rto_cwnd_engine_core.sv
test/tb_top.sv
